// File: hdl/avd_pkg.sv
// avd_pkg: shared types and constants of the adaptive variable-length uint decoder.
// Used by avd_ctrl, avd_dpath and adaptive_varlen_uint_decoder. No dependencies.
`timescale 1ns / 1ps

package avd_pkg;

   localparam int BYTE_W      = 8;
   localparam int BIT_IDX_W   = 3;
   localparam int WIDTH_W     = 6;
   localparam int LIMIT_W     = 10;
   localparam int TALLY_W     = 16;
   localparam int OUT_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [BIT_IDX_W-1:0] LAST_BIT  = 3'd7;
   localparam logic [WIDTH_W-1:0]   WIDTH_MIN = 6'd1;
   localparam logic [WIDTH_W-1:0]   WIDTH_MAX = 6'd32;
   localparam logic [TALLY_W-1:0]   TALLY_MAX = 16'hFFFF;

   localparam logic [WIDTH_W-1:0] RESET_FIRST_WIDTH = 6'd8;
   localparam logic [WIDTH_W-1:0] RESET_LATER_WIDTH = 6'd4;
   localparam logic [LIMIT_W-1:0] RESET_LIMIT       = 10'd8;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_START_INIT  = 3'd0;
   localparam csr_index_type CSR_START_DELTA = 3'd1;
   localparam csr_index_type CSR_INIT_LIMIT  = 3'd2;
   localparam csr_index_type CSR_DELTA_LIMIT = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } avd_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } avd_cmd_type;

   typedef struct packed {
      logic ends;
      logic pend_valid;
      logic out_free;
   } avd_status_type;

endpackage

// File: hdl/avd_ctrl.sv
// avd_ctrl: sequencer that walks the eight bits of a word and flushes the last result.
// Depends on avd_pkg.
`timescale 1ns / 1ps

module avd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  avd_pkg::avd_status_type status,
   output avd_pkg::avd_cmd_type    cmd
);

   avd_pkg::avd_state_type state_ff, state_in;
   logic [avd_pkg::BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= avd_pkg::ST_IDLE;
         bit_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_idx_ff <= bit_idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      bit_idx_in = bit_idx_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         avd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_idx_in = '0;
               state_in   = avd_pkg::ST_RUN;
            end
         end
         avd_pkg::ST_RUN: begin
            // hold the bit while a second result is due and the output is stalled
            if (!(status.ends && status.pend_valid && !status.out_free)) begin
               cmd.step = 1'b1;
               if (bit_idx_ff == avd_pkg::LAST_BIT) begin
                  state_in = avd_pkg::ST_FLUSH;
               end else begin
                  bit_idx_in = bit_idx_ff + 1'b1;
               end
            end
         end
         avd_pkg::ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = avd_pkg::ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = avd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = avd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/avd_dpath.sv
// avd_dpath: bit shifter, segment state, value accumulator, adaptation counters,
// pending result and output register. Depends on avd_pkg.
`timescale 1ns / 1ps

module avd_dpath #(
   parameter int MAX_VALUE_BITS   = 32,
   parameter int ADAPT_COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  avd_pkg::avd_cmd_type                 cmd,
   output avd_pkg::avd_status_type              status,
   input  logic [avd_pkg::BYTE_W-1:0]           req_stream_byte,
   input  logic                                csr_write,
   input  avd_pkg::csr_index_type               csr_index,
   input  logic [avd_pkg::CSR_DATA_W-1:0]       csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [avd_pkg::OUT_W-1:0]            rsp_decoded_value,
   output logic                                rsp_last_of_byte
);

   localparam int IDX_W = $clog2(MAX_VALUE_BITS);
   localparam int SIG_W = $clog2(MAX_VALUE_BITS + 1);
   localparam int ACB   = ADAPT_COUNT_BITS;
   localparam int SUM_W = ADAPT_COUNT_BITS + 18;
   localparam int TW    = avd_pkg::TALLY_W;
   localparam int WW    = avd_pkg::WIDTH_W;
   localparam int OW    = avd_pkg::OUT_W;

   localparam logic signed [SUM_W-1:0] CNT_HI = {{(SUM_W-ACB+1){1'b0}}, {(ACB-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] CNT_LO = ~CNT_HI;
   localparam logic signed [SUM_W-1:0] ONE_S  = {{(SUM_W-1){1'b0}}, 1'b1};
   localparam logic signed [SUM_W-1:0] TWO_S  = {{(SUM_W-2){1'b0}}, 2'b10};
   localparam logic [MAX_VALUE_BITS-1:0] ACC_ONE = {{(MAX_VALUE_BITS-1){1'b0}}, 1'b1};

   function automatic logic [ACB-1:0] sat_count(input logic signed [SUM_W-1:0] v);
      logic [ACB-1:0] r;
      if (v > CNT_HI) begin
         r = CNT_HI[ACB-1:0];
      end else if (v < CNT_LO) begin
         r = CNT_LO[ACB-1:0];
      end else begin
         r = v[ACB-1:0];
      end
      return r;
   endfunction

   function automatic logic [WW-1:0] clamp_width(input logic [WW-1:0] w);
      logic [WW-1:0] r;
      if (w < avd_pkg::WIDTH_MIN) begin
         r = avd_pkg::WIDTH_MIN;
      end else if (w > avd_pkg::WIDTH_MAX) begin
         r = avd_pkg::WIDTH_MAX;
      end else begin
         r = w;
      end
      return r;
   endfunction

   function automatic logic [WW-1:0] widen(input logic [WW-1:0] w);
      return (w >= avd_pkg::WIDTH_MAX) ? avd_pkg::WIDTH_MAX : w + 1'b1;
   endfunction

   function automatic logic [WW-1:0] narrow(input logic [WW-1:0] w);
      return (w <= avd_pkg::WIDTH_MIN) ? avd_pkg::WIDTH_MIN : w - 1'b1;
   endfunction

   logic [avd_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic [MAX_VALUE_BITS-1:0]   acc_ff, acc_in;
   logic [TW-1:0]               bg_ff, bg_in;
   logic [TW-1:0]               sc_ff, sc_in;
   logic [SIG_W-1:0]            sig_ff, sig_in;
   logic [WW-1:0]               left_ff, left_in;
   logic                        cont_ff, cont_in;
   logic [WW-1:0]               fw_ff, fw_in;
   logic [WW-1:0]               lw_ff, lw_in;
   logic [ACB-1:0]              fac_ff, fac_in;
   logic [ACB-1:0]              lac_ff, lac_in;
   logic [avd_pkg::LIMIT_W-1:0] ilim_ff, ilim_in;
   logic [avd_pkg::LIMIT_W-1:0] dlim_ff, dlim_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [OW-1:0]               pend_value_ff, pend_value_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]               rsp_value_ff, rsp_value_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        bit_cur;
   logic                        store_bit;
   logic [MAX_VALUE_BITS-1:0]   acc_new;
   logic [MAX_VALUE_BITS+OW-1:0] acc_wide;
   logic [SIG_W-1:0]            sig_new;
   logic [TW-1:0]               bg_new;
   logic [TW-1:0]               sc_inc;
   logic                        ends;
   logic                        out_free;
   logic                        push;
   logic signed [SUM_W-1:0]     n_s, g_s, s_s, fw_s, fac_s, lac_s;
   logic signed [SUM_W-1:0]     fac_sum, lac_sum;
   logic [ACB-1:0]              fac_sat, lac_sat;
   logic signed [SUM_W-1:0]     fac_sat_s, lac_sat_s, ilim_s, dlim_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         bg_ff         <= '0;
         sc_ff         <= '0;
         sig_ff        <= SIG_W'(1);
         left_ff       <= '0;
         cont_ff       <= 1'b0;
         fw_ff         <= avd_pkg::RESET_FIRST_WIDTH;
         lw_ff         <= avd_pkg::RESET_LATER_WIDTH;
         fac_ff        <= '0;
         lac_ff        <= '0;
         ilim_ff       <= avd_pkg::RESET_LIMIT;
         dlim_ff       <= avd_pkg::RESET_LIMIT;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         bg_ff         <= bg_in;
         sc_ff         <= sc_in;
         sig_ff        <= sig_in;
         left_ff       <= left_in;
         cont_ff       <= cont_in;
         fw_ff         <= fw_in;
         lw_ff         <= lw_in;
         fac_ff        <= fac_in;
         lac_ff        <= lac_in;
         ilim_ff       <= ilim_in;
         dlim_ff       <= dlim_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      pend_value_ff <= pend_value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // data bit update; significance tracks the highest stored one bit
   always_comb begin
      bit_cur   = byte_ff[avd_pkg::BYTE_W-1];
      store_bit = bit_cur && (bg_ff < TW'(MAX_VALUE_BITS));
      acc_new   = store_bit ? (acc_ff | (ACC_ONE << bg_ff[IDX_W-1:0])) : acc_ff;
      sig_new   = store_bit ? (SIG_W'(bg_ff[IDX_W-1:0]) + SIG_W'(1)) : sig_ff;
      bg_new    = (bg_ff == avd_pkg::TALLY_MAX) ? bg_ff : bg_ff + 1'b1;
      sc_inc    = (sc_ff == avd_pkg::TALLY_MAX) ? sc_ff : sc_ff + 1'b1;
      acc_wide  = {{OW{1'b0}}, acc_new};
      ends      = (left_ff == WW'(1)) && !cont_ff;
      out_free  = !rsp_valid_ff || rsp_ready;
      push      = pend_valid_ff && ((cmd.step && ends) || cmd.flush);
   end

   // adaptation counter sums at value end
   always_comb begin
      n_s   = {{(SUM_W-TW){1'b0}}, sc_ff};
      g_s   = {{(SUM_W-TW){1'b0}}, bg_new};
      s_s   = {{(SUM_W-SIG_W){1'b0}}, sig_new};
      fw_s  = {{(SUM_W-WW){1'b0}}, fw_ff};
      fac_s = {{(SUM_W-ACB){fac_ff[ACB-1]}}, fac_ff};
      lac_s = {{(SUM_W-ACB){lac_ff[ACB-1]}}, lac_ff};
      if (n_s == ONE_S) begin
         fac_sum = fac_s - (fw_s - s_s);
         lac_sum = lac_s;
      end else begin
         fac_sum = fac_s + n_s - ONE_S;
         lac_sum = lac_s + (n_s - TWO_S) - (g_s - s_s);
      end
      fac_sat   = sat_count(fac_sum);
      lac_sat   = sat_count(lac_sum);
      fac_sat_s = {{(SUM_W-ACB){fac_sat[ACB-1]}}, fac_sat};
      lac_sat_s = {{(SUM_W-ACB){lac_sat[ACB-1]}}, lac_sat};
      ilim_s    = {{(SUM_W-avd_pkg::LIMIT_W){1'b0}}, ilim_ff};
      dlim_s    = {{(SUM_W-avd_pkg::LIMIT_W){1'b0}}, dlim_ff};
   end

   always_comb begin
      byte_in       = byte_ff;
      acc_in        = acc_ff;
      bg_in         = bg_ff;
      sc_in         = sc_ff;
      sig_in        = sig_ff;
      left_in       = left_ff;
      cont_in       = cont_ff;
      fw_in         = fw_ff;
      lw_in         = lw_ff;
      fac_in        = fac_ff;
      lac_in        = lac_ff;
      ilim_in       = ilim_ff;
      dlim_in       = dlim_ff;
      pend_valid_in = pend_valid_ff;
      pend_value_in = pend_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_write) begin
         case (csr_index)
            avd_pkg::CSR_START_INIT:  fw_in   = clamp_width(csr_data[WW-1:0]);
            avd_pkg::CSR_START_DELTA: lw_in   = clamp_width(csr_data[WW-1:0]);
            avd_pkg::CSR_INIT_LIMIT:  ilim_in = csr_data[avd_pkg::LIMIT_W-1:0];
            avd_pkg::CSR_DELTA_LIMIT: dlim_in = csr_data[avd_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         byte_in = req_stream_byte;
      end

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = pend_value_ff;
         rsp_last_in  = cmd.flush;
      end

      if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end

      if (cmd.step) begin
         byte_in = {byte_ff[avd_pkg::BYTE_W-2:0], 1'b0};
         if (left_ff == '0) begin
            cont_in = bit_cur;
            sc_in   = sc_inc;
            left_in = (sc_inc == TW'(1)) ? fw_ff : lw_ff;
         end else begin
            acc_in  = acc_new;
            bg_in   = bg_new;
            sig_in  = sig_new;
            left_in = left_ff - 1'b1;
            if (ends) begin
               pend_valid_in = 1'b1;
               pend_value_in = acc_wide[OW-1:0];
               acc_in        = '0;
               bg_in         = '0;
               sc_in         = '0;
               sig_in        = SIG_W'(1);
               if (fac_sat_s >= ilim_s) begin
                  fw_in  = widen(fw_ff);
                  fac_in = '0;
               end else if (fac_sat_s <= -ilim_s) begin
                  fw_in  = narrow(fw_ff);
                  fac_in = '0;
               end else begin
                  fac_in = fac_sat;
               end
               if (lac_sat_s >= dlim_s) begin
                  lw_in  = widen(lw_ff);
                  lac_in = '0;
               end else if (lac_sat_s <= -dlim_s) begin
                  lw_in  = narrow(lw_ff);
                  lac_in = '0;
               end else begin
                  lac_in = lac_sat;
               end
            end
         end
      end
   end

   assign status.ends       = ends;
   assign status.pend_valid = pend_valid_ff;
   assign status.out_free   = out_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_decoded_value = rsp_value_ff;
   assign rsp_last_of_byte  = rsp_last_ff;

endmodule

// File: hdl/adaptive_varlen_uint_decoder.sv
// adaptive_varlen_uint_decoder: top level of the adaptive variable-length uint decoder.
// Instantiates avd_ctrl and avd_dpath; depends on avd_pkg.
`timescale 1ns / 1ps

// Decodes a stream of compressed words, one byte each, MSB first, into unsigned
// values built from segments whose widths adapt to the data. The bit walk runs one
// bit per cycle unless a stalled output register (rsp_valid high, rsp_ready low)
// holds it, which happens mid-word when a second result is due. The next word is
// taken only after the load of the shift register, folded into acceptance, eight
// bit steps and one flush of the held result, if any; the flush also waits on a
// stalled output register. Up to four results come out per word;
// rsp_last_of_byte marks the last of them, so each result is held in a pending
// register until the next one or the end of the word is seen. Configuration writes
// are accepted in any cycle and must only be issued while the block is idle.

module adaptive_varlen_uint_decoder #(
   parameter int MAX_VALUE_BITS   = 32,
   parameter int ADAPT_COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [avd_pkg::BYTE_W-1:0]       req_stream_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [avd_pkg::OUT_W-1:0]        rsp_decoded_value,
   output logic                            rsp_last_of_byte,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [avd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [avd_pkg::CSR_DATA_W-1:0]   csr_data
);

   avd_pkg::avd_cmd_type    cmd;
   avd_pkg::avd_status_type status;

   assign csr_ready = 1'b1;

   avd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   avd_dpath #(
      .MAX_VALUE_BITS   (MAX_VALUE_BITS),
      .ADAPT_COUNT_BITS (ADAPT_COUNT_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_stream_byte   (req_stream_byte),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_last_of_byte  (rsp_last_of_byte)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.flush}))
      else $error("more than one datapath command at once");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.ends && status.pend_valid) || cmd.flush |-> status.out_free)
      else $error("result pushed into a stalled output register");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new word accepted while one is being decoded");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.pend_valid)
      else $error("pending result left behind at end of word");

endmodule

// File: bench/avd_decode_checker.sv
`timescale 1ns / 1ps
// avd_decode_checker: watches the byte, decoded-word and register channels of the decoder,
// predicts each decoded word from the accepted bytes and compares in order of arrival.
// Depends on avd_pkg.

module avd_decode_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [avd_pkg::BYTE_W-1:0]      req_stream_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [avd_pkg::OUT_W-1:0]       rsp_decoded_value,
   input  logic                            rsp_last_of_byte,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  avd_pkg::csr_index_type          csr_index,
   input  logic [avd_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              mismatches,
   output int                              awaited
);
   import avd_pkg::*;

   localparam int WORDS_PER_BYTE = 4;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             last;
   } decoded_word_type;

   decoded_word_type expected_words[$];
   decoded_word_type want;
   logic [OUT_W-1:0] found [WORDS_PER_BYTE];

   logic [LIMIT_W-1:0] first_limit, later_limit;
   logic [WIDTH_W-1:0] first_width, later_width, bits_left;
   logic [OUT_W-1:0]   value_bits, shifted;
   logic [TALLY_W-1:0] bits_taken, segments;
   logic               more_follows;
   int                 first_tally, later_tally;
   int                 i, produced, sig_len, errors;

   function automatic logic [WIDTH_W-1:0] clamp_width(input int w);
      if (w < int'(WIDTH_MIN)) return WIDTH_MIN;
      if (w > int'(WIDTH_MAX)) return WIDTH_MAX;
      return w[WIDTH_W-1:0];
   endfunction

   function automatic int sat_tally(input int v);
      int hi;
      hi = (1 << (TALLY_W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   task automatic adapt_width(inout int tally, inout logic [WIDTH_W-1:0] width,
                              input logic [LIMIT_W-1:0] limit);
      if (tally >= int'(limit)) begin
         width = clamp_width(int'(width) + 1);
         tally = 0;
      end else if (tally <= -int'(limit)) begin
         width = clamp_width(int'(width) - 1);
         tally = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         first_limit  = RESET_LIMIT;
         later_limit  = RESET_LIMIT;
         first_width  = RESET_FIRST_WIDTH;
         later_width  = RESET_LATER_WIDTH;
         bits_left    = '0;
         value_bits   = '0;
         bits_taken   = '0;
         segments     = '0;
         more_follows = 1'b0;
         first_tally  = 0;
         later_tally  = 0;
         errors       = 0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_INIT:  first_width = clamp_width(int'(csr_data[WIDTH_W-1:0]));
               CSR_START_DELTA: later_width = clamp_width(int'(csr_data[WIDTH_W-1:0]));
               CSR_INIT_LIMIT:  first_limit = csr_data[LIMIT_W-1:0];
               CSR_DELTA_LIMIT: later_limit = csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            produced = 0;
            for (i = BYTE_W - 1; i >= 0; i--) begin
               if (bits_left == 0) begin
                  more_follows = req_stream_byte[i];
                  if (segments != TALLY_MAX) segments = segments + 1'b1;
                  bits_left = (segments == 1) ? first_width : later_width;
               end else begin
                  if (req_stream_byte[i] && bits_taken < OUT_W) value_bits[bits_taken] = 1'b1;
                  if (bits_taken != TALLY_MAX) bits_taken = bits_taken + 1'b1;
                  bits_left = bits_left - 1'b1;
                  if (bits_left == 0 && !more_follows) begin
                     if (produced < WORDS_PER_BYTE) begin
                        found[produced] = value_bits;
                        produced++;
                     end
                     sig_len = 1;
                     shifted = value_bits;
                     while (shifted > 1) begin
                        sig_len++;
                        shifted = shifted >> 1;
                     end
                     if (segments == 1) begin
                        first_tally = sat_tally(first_tally - (int'(first_width) - sig_len));
                     end else begin
                        first_tally = sat_tally(first_tally + int'(segments) - 1);
                        later_tally = sat_tally(later_tally + (int'(segments) - 2)
                                                - (int'(bits_taken) - sig_len));
                     end
                     adapt_width(first_tally, first_width, first_limit);
                     adapt_width(later_tally, later_width, later_limit);
                     value_bits = '0;
                     bits_taken = '0;
                     segments   = '0;
                  end
               end
            end
            for (i = 0; i < produced; i++) begin
               want.value = found[i];
               want.last  = (i == produced - 1);
               expected_words.push_back(want);
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("decoded_value expected none actual %h", rsp_decoded_value);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_decoded_value !== want.value) begin
                  $error("decoded_value expected %h actual %h", want.value, rsp_decoded_value);
                  errors++;
               end
               if (rsp_last_of_byte !== want.last) begin
                  $error("last_of_byte expected %b actual %b", want.last, rsp_last_of_byte);
                  errors++;
               end
            end
         end
      end
      mismatches <= errors;
      awaited    <= expected_words.size();
   end

endmodule

// File: bench/adaptive_varlen_uint_decoder_tb.sv
`timescale 1ns / 1ps
// adaptive_varlen_uint_decoder_tb: drives bytes, register writes and result backpressure
// into adaptive_varlen_uint_decoder; avd_decode_checker does the checking. Uses avd_pkg.

module adaptive_varlen_uint_decoder_tb;
   import avd_pkg::*;

   localparam int STALL_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 20;
   localparam csr_index_type CSR_UNUSED_FIRST = 3'd4;
   localparam csr_index_type CSR_UNUSED_LAST  = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_stream_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [OUT_W-1:0]       rsp_decoded_value;
   logic                   rsp_last_of_byte;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int   mismatches;
   int   awaited;
   int   stall_left = 0;
   int   idle_cycles = 0;
   logic calm = 1'b0;

   adaptive_varlen_uint_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   avd_decode_checker i_decode_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_decoded_value (rsp_decoded_value),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatches        (mismatches),
      .awaited           (awaited)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side backpressure: random bursts with rsp_ready low, none once calm is set
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(1, 11);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [BYTE_W-1:0] pick_byte();
      logic [31:0] a, b;
      a = $urandom;
      b = $urandom;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return a[BYTE_W-1:0] & b[BYTE_W-1:0];
         4:       return a[BYTE_W-1:0] | b[BYTE_W-1:0];
         default: return a[BYTE_W-1:0];
      endcase
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // sender holds off until every decoded word is in and the bit walk is done
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] first_start,
                            input logic [CSR_DATA_W-1:0] later_start,
                            input logic [CSR_DATA_W-1:0] first_limit,
                            input logic [CSR_DATA_W-1:0] later_limit,
                            input logic with_unused);
      int j;
      settle();
      if (with_unused) begin
         for (j = CSR_UNUSED_FIRST; j <= CSR_UNUSED_LAST; j++) begin
            csr_write(csr_index_type'(j), CSR_DATA_W'($urandom_range(0, 1023)));
         end
      end
      csr_write(CSR_START_INIT, first_start);
      csr_write(CSR_START_DELTA, later_start);
      csr_write(CSR_INIT_LIMIT, first_limit);
      csr_write(CSR_DELTA_LIMIT, later_limit);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset widths; a long run of ones overflows the 32-bit value
      send_byte(8'h00);
      repeat (5) send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h7F);
      repeat (30) send_byte(pick_byte());

      // narrowest widths, up to four words per byte
      configure(10'd1, 10'd1, 10'd1, 10'd1, 1'b0);
      send_byte(8'h00);
      send_byte(8'h11);
      send_byte(8'hFF);
      send_byte(8'h00);
      repeat (30) send_byte(pick_byte());

      // out-of-range widths get clamped, zero limits adapt after every value
      configure(10'h040, 10'h3FF, 10'd0, 10'd0, 1'b1);
      send_byte(8'h00);
      send_byte(8'hC0);
      send_byte(8'hFF);
      send_byte(8'h00);
      repeat (30) send_byte(pick_byte());

      configure(10'd32, 10'd32, 10'd1023, 10'd1023, 1'b0);
      repeat (30) send_byte(pick_byte());
      repeat (5) send_byte(8'h00);

      configure(10'd5, 10'd3, 10'd3, 10'd12, 1'b1);
      repeat (35) send_byte(pick_byte());

      calm <= 1'b1;
      configure(10'd8, 10'd4, 10'd8, 10'd8, 1'b0);
      repeat (30) send_byte(pick_byte());

      settle();
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
